// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Status and meta codes
  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [3:0] HI_NOTE_OFF = 4'b1000;
  localparam logic [3:0] HI_NOTE_ON  = 4'b1001;
  localparam logic [3:0] HI_PROGRAM  = 4'b1100;
  localparam logic [3:0] HI_PRESSURE = 4'b1101;

  // Result queue depth
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] delta_ticks;
    logic [3:0]  channel;
    logic [6:0]  note_number;
    logic        note_on;
    logic [6:0]  velocity;
    logic [23:0] tempo_value;
    logic        last_of_run;
  } result_t;

  // Results produced by one byte: count, then up to two in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== rtl/mtep_parser.sv =====
module mtep_parser import mtep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_start_i,
  output push_t      push_o
);

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_DELTA     = 3'd1;
  localparam logic [2:0] PH_STATUS    = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_META_TYPE = 3'd4;
  localparam logic [2:0] PH_META_LEN  = 3'd5;
  localparam logic [2:0] PH_META_DATA = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  header_count_q, header_count_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] delta_accum_q, delta_accum_d;
  logic [7:0]  status_byte_q, status_byte_d;
  logic [1:0]  data_count_q, data_count_d;
  logic [6:0]  first_data_q, first_data_d;
  logic [7:0]  meta_type_q, meta_type_d;
  logic [31:0] meta_left_q, meta_left_d;
  logic [23:0] tempo_accum_q, tempo_accum_d;

  // A chunk start restarts the header before this byte is parsed
  logic [2:0]  phase_eff;
  logic [2:0]  header_count_eff;
  logic [31:0] bytes_left_eff;

  assign phase_eff        = chunk_start_i ? PH_HEADER : phase_q;
  assign header_count_eff = chunk_start_i ? 3'd0 : header_count_q;
  assign bytes_left_eff   = chunk_start_i ? 32'd0 : bytes_left_q;

  logic        ev_vld;
  logic        end_vld;
  result_t     ev;
  result_t     end_res;
  logic [3:0]  hi_nib;
  logic [3:0]  stat_hi;
  logic        is_on;
  logic [31:0] meta_len_n;
  logic [31:0] meta_dec;
  logic [23:0] tempo_n;

  assign hi_nib     = data_byte_i[7:4];
  assign stat_hi    = status_byte_q[7:4];
  assign is_on      = (stat_hi == HI_NOTE_ON);
  assign meta_len_n = {meta_left_q[24:0], data_byte_i[6:0]};
  assign meta_dec   = meta_left_q - 32'd1;
  assign tempo_n    = {tempo_accum_q[15:0], data_byte_i};

  // Step the parser on each accepted byte
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    bytes_left_d   = bytes_left_q;
    delta_accum_d  = delta_accum_q;
    status_byte_d  = status_byte_q;
    data_count_d   = data_count_q;
    first_data_d   = first_data_q;
    meta_type_d    = meta_type_q;
    meta_left_d    = meta_left_q;
    tempo_accum_d  = tempo_accum_q;
    ev_vld         = 1'b0;
    end_vld        = 1'b0;
    ev             = '0;

    if (fire_i) begin
      phase_d        = phase_eff;
      header_count_d = header_count_eff;
      bytes_left_d   = bytes_left_eff;

      if (phase_eff == PH_DONE) begin
        // ignore bytes until the next chunk
      end else if (phase_eff == PH_HEADER) begin
        if (header_count_eff[2]) begin
          bytes_left_d = {bytes_left_eff[23:0], data_byte_i};
        end
        header_count_d = header_count_eff + 3'd1;
        if (header_count_d == 3'd0) begin
          if (bytes_left_d == 32'd0) begin
            end_vld = 1'b1;
            phase_d = PH_DONE;
          end else begin
            delta_accum_d = 32'd0;
            phase_d       = PH_DELTA;
          end
        end
      end else begin
        case (phase_eff)
          PH_DELTA: begin
            delta_accum_d = {delta_accum_q[24:0], data_byte_i[6:0]};
            if (!data_byte_i[7]) begin
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (data_byte_i == STATUS_META) begin
              phase_d = PH_META_TYPE;
            end else begin
              status_byte_d = data_byte_i;
              data_count_d  = (hi_nib == HI_PROGRAM || hi_nib == HI_PRESSURE) ? 2'd1 : 2'd2;
              phase_d       = PH_DATA;
            end
          end
          PH_DATA: begin
            if (data_count_q == 2'd2) begin
              first_data_d = data_byte_i[6:0];
              data_count_d = 2'd1;
            end else begin
              if (stat_hi == HI_NOTE_OFF || stat_hi == HI_NOTE_ON) begin
                ev_vld         = 1'b1;
                ev.kind        = KIND_NOTE;
                ev.delta_ticks = delta_accum_q;
                ev.channel     = status_byte_q[3:0];
                ev.note_number = first_data_q;
                ev.note_on     = is_on;
                ev.velocity    = is_on ? data_byte_i[6:0] : 7'd0;
              end
              data_count_d  = 2'd0;
              delta_accum_d = 32'd0;
              phase_d       = PH_DELTA;
            end
          end
          PH_META_TYPE: begin
            meta_type_d   = data_byte_i;
            meta_left_d   = 32'd0;
            tempo_accum_d = 24'd0;
            phase_d       = PH_META_LEN;
          end
          PH_META_LEN: begin
            meta_left_d = meta_len_n;
            if (!data_byte_i[7]) begin
              if (meta_len_n == 32'd0) begin
                if (meta_type_q == META_TEMPO) begin
                  ev_vld         = 1'b1;
                  ev.kind        = KIND_TEMPO;
                  ev.delta_ticks = delta_accum_q;
                  ev.tempo_value = tempo_accum_q;
                end
                delta_accum_d = 32'd0;
                phase_d       = PH_DELTA;
              end else begin
                phase_d = PH_META_DATA;
              end
            end
          end
          PH_META_DATA: begin
            tempo_accum_d = tempo_n;
            meta_left_d   = meta_dec;
            if (meta_dec == 32'd0) begin
              if (meta_type_q == META_TEMPO) begin
                ev_vld         = 1'b1;
                ev.kind        = KIND_TEMPO;
                ev.delta_ticks = delta_accum_q;
                ev.tempo_value = tempo_n;
              end
              delta_accum_d = 32'd0;
              phase_d       = PH_DELTA;
            end
          end
          default: begin
            phase_d = phase_eff;
          end
        endcase

        // Count down the body; its last byte closes the track
        bytes_left_d = bytes_left_eff - 32'd1;
        if (bytes_left_d == 32'd0) begin
          end_vld = 1'b1;
          phase_d = PH_DONE;
        end
      end
    end
  end

  // Order the results: event first, end marker after it
  always_comb begin
    end_res             = '0;
    end_res.kind        = KIND_END;
    end_res.last_of_run = 1'b1;
    push_o              = '0;
    if (ev_vld) begin
      push_o.first             = ev;
      push_o.first.last_of_run = !end_vld;
      if (end_vld) begin
        push_o.second = end_res;
        push_o.count  = 2'd2;
      end else begin
        push_o.count  = 2'd1;
      end
    end else if (end_vld) begin
      push_o.first = end_res;
      push_o.count = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= 3'd0;
      bytes_left_q   <= 32'd0;
      delta_accum_q  <= 32'd0;
      status_byte_q  <= 8'd0;
      data_count_q   <= 2'd0;
      first_data_q   <= 7'd0;
      meta_type_q    <= 8'd0;
      meta_left_q    <= 32'd0;
      tempo_accum_q  <= 24'd0;
    end else begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      bytes_left_q   <= bytes_left_d;
      delta_accum_q  <= delta_accum_d;
      status_byte_q  <= status_byte_d;
      data_count_q   <= data_count_d;
      first_data_q   <= first_data_d;
      meta_type_q    <= meta_type_d;
      meta_left_q    <= meta_left_d;
      tempo_accum_q  <= tempo_accum_d;
    end
  end

endmodule

// ===== rtl/mtep_out_queue.sv =====
module mtep_out_queue import mtep_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    has_room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t               entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic [QUEUE_AW-1:0]   wr_ptr_next;

  // Room for two results is needed before a byte is taken
  assign has_room_o  = (count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign valid_o     = (count_q != '0);
  assign head_o      = entries_q[rd_ptr_q];
  assign wr_ptr_next = wr_ptr_q + QUEUE_AW'(1);

  // Advance pointers and occupancy
  always_comb begin
    rd_ptr_d = pop_i ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    wr_ptr_d = wr_ptr_q + QUEUE_AW'(push_i.count);
    count_d  = count_q + (QUEUE_AW + 1)'(push_i.count) - (QUEUE_AW + 1)'(pop_i);
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/midi_track_event_parser_top.sv =====
// MIDI track chunk parser. Feed the chunk one byte per transaction, with
// chunk_start_i high on the first header byte. The block accepts a byte in
// every cycle while the queue has room; its results appear at the output
// in the cycle after the byte is taken, from a four-entry result queue. A
// byte that both finishes an event and ends the track body yields two
// results (event, then end of track), which leave the queue one at a time.
// The input stalls only while the queue holds more than two results, which
// happens only when the output side holds off; with out_ready_i held high
// the input never stalls. The parser itself has no busy state.
module midi_track_event_parser_top import mtep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] delta_ticks_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  note_number_o,
  output logic        note_on_o,
  output logic [6:0]  velocity_o,
  output logic [23:0] tempo_value_o,
  output logic        last_of_run_o
);

  logic    fire;
  logic    pop;
  push_t   push;
  result_t head;

  assign fire = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  mtep_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_byte_i   (data_byte_i),
    .chunk_start_i (chunk_start_i),
    .push_o        (push)
  );

  mtep_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .has_room_o (in_ready_o),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  // Drive result fields from the queue head
  assign kind_o        = head.kind;
  assign delta_ticks_o = head.delta_ticks;
  assign channel_o     = head.channel;
  assign note_number_o = head.note_number;
  assign note_on_o     = head.note_on;
  assign velocity_o    = head.velocity;
  assign tempo_value_o = head.tempo_value;
  assign last_of_run_o = head.last_of_run;

endmodule
